[hw/rtl/bpa_pkg.sv]
// Package with the types, constants and codes of the buddy page allocator.
`default_nettype none
package bpa_pkg;

   // Geometry of the managed region
   localparam int PAGES      = 1024;
   localparam int PAGE_SHIFT = 12;
   localparam int TOP_ORDER  = 10;

   // Field widths
   localparam int ADDR_W = 48;
   localparam int REQ_W  = 32;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;
   localparam int ORD_W  = 4;
   localparam int TP_W   = 11;

   // Derived widths
   localparam int IDX_W   = $clog2(PAGES);
   localparam int NODE_W  = IDX_W + 1;
   localparam int NEED_W  = REQ_W + 1 - PAGE_SHIFT;
   localparam int FRONT_N = TOP_ORDER + 1;

   localparam logic [NODE_W-1:0] NIL = NODE_W'(PAGES);
   localparam logic [REQ_W:0]    PAGE_MASK = (REQ_W+1)'((1 << PAGE_SHIFT) - 1);

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_INIT  = 2'd2;
   localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

   // Status codes
   localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
   localparam logic [ST_W-1:0] ST_NO_BLOCK = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;

   // Register indexes
   localparam logic CSR_TOTAL_PAGES = 1'b0;
   localparam logic CSR_BASE        = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [REQ_W-1:0]  request_bytes;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [ADDR_W-1:0] block_address;
      logic [ORD_W-1:0]  size_order;
   } rsp_type;

   typedef struct packed {
      logic [TP_W-1:0]   page_total;
      logic [ADDR_W-1:0] base_address;
   } cfg_type;

   // Per-page marks
   typedef struct packed {
      logic [ORD_W-1:0] order;
      logic             first;
      logic             used;
   } pg_type;

endpackage
`default_nettype wire

[hw/rtl/buddy_page_allocator_top.sv]
// Top level of the buddy page allocator: registers, command intake and result register.
//
//   channel  direction  ports                              transfer when
//   req      in         req_valid, req_stall, req_data     req_valid & !req_stall
//   rsp      out        rsp_valid, rsp_stall, rsp_data     rsp_valid & !rsp_stall
//   csr      in         csr_we, csr_index, csr_wdata       csr_we
//
// One command at a time; the sequencer rewrites page marks one page a cycle.
// Allocate pops the block, splits off and pushes the upper half at each split level, then
// marks the final block in use. Free aligns to the head of the block, clears its marks,
// merges with a free buddy at each merge level, then pushes the block onto its list.
// Initialize sweeps all pages. After reset the page marks are cleared.
// req_stall is high whenever the sequencer is busy or holds an untaken result.
`default_nettype none
module buddy_page_allocator_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire bpa_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output bpa_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_we,
   input  wire logic                         csr_index,
   input  wire logic [bpa_pkg::ADDR_W-1:0]   csr_wdata
);
   import bpa_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    core_idle, res_valid, res_take;
   rsp_type res;

   // Write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_PAGES: cfg_in.page_total   = csr_wdata[TP_W-1:0];
            CSR_BASE:        cfg_in.base_address = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Load the output register when it is empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{page_total: TP_W'(PAGES), base_address: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   bpa_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (req_valid && core_idle),
      .cmd       (req_data),
      .idle      (core_idle),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   assign req_stall = !core_idle;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block still idle after accepting a command");
   a_no_block_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_NO_BLOCK) |->
      (rsp_data.block_address == '0 && rsp_data.size_order == '0))
      else $error("failed allocation carries a block");
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_RANGE) |->
      (rsp_data.block_address == '0 && rsp_data.size_order == '0))
      else $error("out of range free carries a block");
   a_take_free_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data))
      else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire

[hw/rtl/bpa_core.sv]
// Sequencer, page mark memory and free list links of the buddy page allocator.
`default_nettype none
module bpa_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bpa_pkg::cfg_type cfg,
   input  wire logic             cmd_valid,
   input  wire bpa_pkg::req_type cmd,
   output logic                  idle,
   output logic                  res_valid,
   output bpa_pkg::rsp_type      res,
   input  wire logic             res_take
);
   import bpa_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_INIT, S_A_WAIT, S_A_POP, S_A_SPLIT, S_A_DONE,
      S_F_W1, S_F_ALIGN, S_F_W2, S_F_CHK, S_F_MERGE, S_F_BW, S_F_BCHK,
      S_F_PUSH, S_F_DONE, S_FILL, S_PUSH1, S_PUSH2, S_HOLD
   } state_type;

   // Memories
   pg_type            pg_mem [PAGES];
   logic [NODE_W-1:0] nx_mem [PAGES];
   logic [NODE_W-1:0] pv_mem [PAGES];
   pg_type            pg_q;
   logic [NODE_W-1:0] nx_q;
   logic [NODE_W-1:0] pv_q;

   logic              pg_we, nx_we, pv_we;
   logic [IDX_W-1:0]  pg_wa, nx_wa, pv_wa;
   pg_type            pg_wd;
   logic [NODE_W-1:0] nx_wd, pv_wd;

   // Registers
   state_type         state_ff, state_in;
   state_type         after_fill_ff, after_fill_in;
   state_type         push_ret_ff, push_ret_in;
   logic [IDX_W-1:0]  node_ff, node_in;
   logic [IDX_W-1:0]  aux_ff, aux_in;
   logic [IDX_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [ORD_W-1:0]  ord_ff, ord_in;
   logic [ORD_W-1:0]  cur_ff, cur_in;
   logic [NODE_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]  fill_base_ff, fill_base_in;
   logic [ORD_W-1:0]  fill_ord_ff, fill_ord_in;
   logic              fill_use_ff, fill_use_in;
   logic [IDX_W-1:0]  push_node_ff, push_node_in;
   logic [ORD_W-1:0]  push_ord_ff, push_ord_in;
   logic [NODE_W-1:0] front_ff [FRONT_N];
   logic [NODE_W-1:0] front_in [FRONT_N];
   logic [ORD_W-1:0]  largest_ff, largest_in;
   logic [NODE_W-1:0] lim_ff, lim_in;
   rsp_type           res_ff, res_in;
   logic              res_valid_ff, res_valid_in;

   // Front list write port
   logic              fw_en, fw_clr;
   logic [ORD_W-1:0]  fw_idx;
   logic [NODE_W-1:0] fw_val;

   // Command decode
   logic [NODE_W-1:0] count;
   logic [ORD_W-1:0]  init_lo;
   logic [NODE_W-1:0] init_last;
   logic [REQ_W:0]    need_sum;
   logic [NEED_W-1:0] need, need_m1;
   logic [ORD_W:0]    need_ord;
   logic              hit;
   logic [ORD_W-1:0]  hit_ord;
   logic [NODE_W-1:0] hit_node;
   logic              below;
   logic [ADDR_W-1:0] diff;
   logic              out_of_range;

   function automatic logic [NODE_W-1:0] front_at(input logic [NODE_W-1:0] fr [FRONT_N],
                                                 input logic [ORD_W-1:0] k);
      logic [NODE_W-1:0] v;
      v = NIL;
      for (int i = 0; i < FRONT_N; i++) begin
         if (ORD_W'(i) == k) v = fr[i];
      end
      return v;
   endfunction

   // Decode managed count, init order, request order, list search and range
   always_comb begin
      count = (cfg.page_total > TP_W'(PAGES)) ? NODE_W'(PAGES) : NODE_W'(cfg.page_total);
      init_lo = '0;
      for (int i = 0; i < NODE_W; i++) begin
         if (count[i]) init_lo = (i > TOP_ORDER) ? ORD_W'(TOP_ORDER) : ORD_W'(i);
      end
      init_last = ((count >> init_lo) - NODE_W'(1)) << init_lo;

      need_sum = {1'b0, cmd.request_bytes} + PAGE_MASK;
      need     = need_sum[REQ_W:PAGE_SHIFT];
      need_m1  = need - NEED_W'(1);
      need_ord = '0;
      if (need > NEED_W'(1)) begin
         for (int i = 0; i < NEED_W; i++) begin
            if (need_m1[i]) need_ord = (ORD_W+1)'(i + 1);
         end
      end

      hit     = 1'b0;
      hit_ord = '0;
      for (int i = TOP_ORDER; i >= 0; i--) begin
         if ((ORD_W+1)'(i) >= need_ord && ORD_W'(i) <= largest_ff && front_ff[i] != NIL) begin
            hit     = 1'b1;
            hit_ord = ORD_W'(i);
         end
      end
      hit_node = front_at(front_ff, hit_ord);

      below        = cmd.address < cfg.base_address;
      diff         = cmd.address - cfg.base_address;
      out_of_range = below ||
                     (diff[ADDR_W-1:PAGE_SHIFT] >= (ADDR_W-PAGE_SHIFT)'(count));
   end

   // Sequencer next state
   always_comb begin
      logic [IDX_W-1:0]  idx;
      logic [NODE_W:0]   ip, span2, lim2;
      logic              head;
      logic [NODE_W-1:0] fspan;
      logic [ORD_W-1:0]  c;
      logic [IDX_W-1:0]  half, bud, merged, amask;
      logic [NODE_W-1:0] hd;

      state_in      = state_ff;
      after_fill_in = after_fill_ff;
      push_ret_in   = push_ret_ff;
      node_in       = node_ff;
      aux_in        = aux_ff;
      rd_addr_in    = rd_addr_ff;
      ord_in        = ord_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      fill_base_in  = fill_base_ff;
      fill_ord_in   = fill_ord_ff;
      fill_use_in   = fill_use_ff;
      push_node_in  = push_node_ff;
      push_ord_in   = push_ord_ff;
      largest_in    = largest_ff;
      lim_in        = lim_ff;
      res_in        = res_ff;
      res_valid_in  = res_valid_ff;
      pg_we = 1'b0; pg_wa = '0; pg_wd = '0;
      nx_we = 1'b0; nx_wa = '0; nx_wd = NIL;
      pv_we = 1'b0; pv_wa = '0; pv_wd = NIL;
      fw_en = 1'b0; fw_clr = 1'b0; fw_idx = '0; fw_val = NIL;
      idx = cnt_ff[IDX_W-1:0];
      ip = {1'b0, cnt_ff};
      span2 = (NODE_W+1)'(1) << ord_ff;
      lim2 = {1'b0, lim_ff};
      head = 1'b0;
      fspan = NODE_W'(1) << fill_ord_ff;
      c = cur_ff - ORD_W'(1);
      half = node_ff + (IDX_W'(1) << c);
      bud = node_ff ^ (IDX_W'(1) << ord_ff);
      merged = (aux_ff < node_ff) ? aux_ff : node_ff;
      amask = ~(IDX_W'((NODE_W'(1) << pg_q.order) - NODE_W'(1)));
      hd = front_at(front_ff, push_ord_ff);

      unique case (state_ff)
         // Zero the page marks after reset
         S_CLEAR: begin
            pg_we  = 1'b1;
            pg_wa  = idx;
            cnt_in = cnt_ff + NODE_W'(1);
            if (cnt_ff == NODE_W'(PAGES - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               res_in = '{status: ST_DONE, block_address: '0, size_order: '0};
               unique case (cmd.operation)
                  OP_ALLOC: begin
                     if (need_ord > {1'b0, largest_ff} || !hit) begin
                        res_in.status = ST_NO_BLOCK;
                        res_valid_in  = 1'b1;
                        state_in      = S_HOLD;
                     end else begin
                        node_in    = hit_node[IDX_W-1:0];
                        rd_addr_in = hit_node[IDX_W-1:0];
                        cur_in     = hit_ord;
                        ord_in     = need_ord[ORD_W-1:0];
                        state_in   = S_A_WAIT;
                     end
                  end
                  OP_FREE: begin
                     if (out_of_range) begin
                        res_in.status = ST_RANGE;
                        res_valid_in  = 1'b1;
                        state_in      = S_HOLD;
                     end else begin
                        node_in    = diff[PAGE_SHIFT +: IDX_W];
                        rd_addr_in = diff[PAGE_SHIFT +: IDX_W];
                        state_in   = S_F_W1;
                     end
                  end
                  OP_INIT: begin
                     largest_in = init_lo;
                     fw_clr     = 1'b1;
                     if (count != '0) begin
                        fw_en  = 1'b1;
                        fw_idx = init_lo;
                        fw_val = init_last;
                     end
                     lim_in   = count;
                     ord_in   = init_lo;
                     cnt_in   = '0;
                     state_in = S_INIT;
                  end
                  default: begin
                     res_valid_in = 1'b1;
                     state_in     = S_HOLD;
                  end
               endcase
            end
         end
         // Sweep all pages: marks, block heads and their links
         S_INIT: begin
            head  = ((ip & (span2 - (NODE_W+1)'(1))) == '0) && (ip + span2 <= lim2);
            pg_we = 1'b1;
            pg_wa = idx;
            pg_wd = '{order: (cnt_ff < lim_ff) ? ord_ff : '0, first: head, used: 1'b0};
            if (head) begin
               nx_we = 1'b1;
               nx_wa = idx;
               nx_wd = (cnt_ff == '0) ? NIL : NODE_W'(ip - span2);
               pv_we = 1'b1;
               pv_wa = idx;
               pv_wd = (ip + span2 + span2 <= lim2) ? NODE_W'(ip + span2) : NIL;
            end
            cnt_in = cnt_ff + NODE_W'(1);
            if (cnt_ff == NODE_W'(PAGES - 1)) begin
               cnt_in       = '0;
               res_valid_in = 1'b1;
               state_in     = S_HOLD;
            end
         end
         S_A_WAIT: state_in = S_A_POP;
         // Drop the front block from its list
         S_A_POP: begin
            fw_en  = 1'b1;
            fw_idx = cur_ff;
            fw_val = nx_q;
            if (nx_q != NIL) begin
               pv_we = 1'b1;
               pv_wa = nx_q[IDX_W-1:0];
               pv_wd = NIL;
            end
            state_in = S_A_SPLIT;
         end
         // Split off the upper half, or mark the final block in use
         S_A_SPLIT: begin
            cnt_in = '0;
            if (cur_ff > ord_ff) begin
               cur_in        = c;
               fill_base_in  = half;
               fill_ord_in   = c;
               fill_use_in   = 1'b0;
               after_fill_in = S_PUSH1;
               push_node_in  = half;
               push_ord_in   = c;
               push_ret_in   = S_A_SPLIT;
            end else begin
               fill_base_in  = node_ff;
               fill_ord_in   = cur_ff;
               fill_use_in   = 1'b1;
               after_fill_in = S_A_DONE;
            end
            state_in = S_FILL;
         end
         S_A_DONE: begin
            res_in = '{status: ST_DONE,
                       block_address: cfg.base_address +
                                      (ADDR_W'(node_ff) << PAGE_SHIFT),
                       size_order: cur_ff};
            res_valid_in = 1'b1;
            state_in     = S_HOLD;
         end
         S_F_W1: state_in = S_F_ALIGN;
         // Align to the head of the block
         S_F_ALIGN: begin
            if (!pg_q.first) begin
               node_in    = node_ff & amask;
               rd_addr_in = node_ff & amask;
            end
            state_in = S_F_W2;
         end
         S_F_W2: state_in = S_F_CHK;
         S_F_CHK: begin
            ord_in = pg_q.order;
            if (!pg_q.used) begin
               res_in       = '{status: ST_DONE, block_address: '0, size_order: pg_q.order};
               res_valid_in = 1'b1;
               state_in     = S_HOLD;
            end else begin
               fill_base_in  = node_ff;
               fill_ord_in   = pg_q.order;
               fill_use_in   = 1'b0;
               after_fill_in = S_F_MERGE;
               cnt_in        = '0;
               state_in      = S_FILL;
            end
         end
         S_F_MERGE: begin
            if (ord_ff < largest_ff && {1'b0, bud} < count) begin
               rd_addr_in = bud;
               aux_in     = bud;
               state_in   = S_F_BW;
            end else begin
               state_in = S_F_PUSH;
            end
         end
         S_F_BW: state_in = S_F_BCHK;
         // Merge with a free buddy of equal order
         S_F_BCHK: begin
            if (!pg_q.first || pg_q.used || pg_q.order != ord_ff) begin
               state_in = S_F_PUSH;
            end else begin
               if (pv_q != NIL) begin
                  nx_we = 1'b1;
                  nx_wa = pv_q[IDX_W-1:0];
                  nx_wd = nx_q;
               end else begin
                  fw_en  = 1'b1;
                  fw_idx = ord_ff;
                  fw_val = nx_q;
               end
               if (nx_q != NIL) begin
                  pv_we = 1'b1;
                  pv_wa = nx_q[IDX_W-1:0];
                  pv_wd = pv_q;
               end
               node_in       = merged;
               ord_in        = ord_ff + ORD_W'(1);
               fill_base_in  = merged;
               fill_ord_in   = ord_ff + ORD_W'(1);
               fill_use_in   = 1'b0;
               after_fill_in = S_F_MERGE;
               cnt_in        = '0;
               state_in      = S_FILL;
            end
         end
         S_F_PUSH: begin
            push_node_in = node_ff;
            push_ord_in  = ord_ff;
            push_ret_in  = S_F_DONE;
            state_in     = S_PUSH1;
         end
         S_F_DONE: begin
            res_in       = '{status: ST_DONE, block_address: '0, size_order: ord_ff};
            res_valid_in = 1'b1;
            state_in     = S_HOLD;
         end
         // Rewrite the marks of one block, one page a cycle
         S_FILL: begin
            pg_we  = 1'b1;
            pg_wa  = fill_base_ff + cnt_ff[IDX_W-1:0];
            pg_wd  = '{order: fill_ord_ff, first: (cnt_ff == '0), used: fill_use_ff};
            cnt_in = cnt_ff + NODE_W'(1);
            if (cnt_ff == fspan - NODE_W'(1)) begin
               cnt_in   = '0;
               state_in = after_fill_ff;
            end
         end
         // Push a block onto the front of its list
         S_PUSH1: begin
            pv_we  = 1'b1;
            pv_wa  = push_node_ff;
            pv_wd  = NIL;
            nx_we  = 1'b1;
            nx_wa  = push_node_ff;
            nx_wd  = hd;
            fw_en  = 1'b1;
            fw_idx = push_ord_ff;
            fw_val = {1'b0, push_node_ff};
            if (hd != NIL) begin
               aux_in   = hd[IDX_W-1:0];
               state_in = S_PUSH2;
            end else begin
               state_in = push_ret_ff;
            end
         end
         S_PUSH2: begin
            pv_we    = 1'b1;
            pv_wa    = aux_ff;
            pv_wd    = {1'b0, push_node_ff};
            state_in = push_ret_ff;
         end
         // Hold the result until the output register takes it
         S_HOLD: begin
            if (res_take) begin
               res_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      for (int i = 0; i < FRONT_N; i++) begin
         front_in[i] = fw_clr ? NIL : front_ff[i];
         if (fw_en && fw_idx == ORD_W'(i)) front_in[i] = fw_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         largest_ff   <= '0;
         res_valid_ff <= 1'b0;
         for (int i = 0; i < FRONT_N; i++) front_ff[i] <= NIL;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         largest_ff   <= largest_in;
         res_valid_ff <= res_valid_in;
         for (int i = 0; i < FRONT_N; i++) front_ff[i] <= front_in[i];
      end
      after_fill_ff <= after_fill_in;
      push_ret_ff   <= push_ret_in;
      node_ff       <= node_in;
      aux_ff        <= aux_in;
      rd_addr_ff    <= rd_addr_in;
      ord_ff        <= ord_in;
      cur_ff        <= cur_in;
      fill_base_ff  <= fill_base_in;
      fill_ord_ff   <= fill_ord_in;
      fill_use_ff   <= fill_use_in;
      push_node_ff  <= push_node_in;
      push_ord_ff   <= push_ord_in;
      lim_ff        <= lim_in;
      res_ff        <= res_in;
   end

   // Memory ports: one write and one registered read each
   always_ff @(posedge clock) begin
      if (pg_we) pg_mem[pg_wa] <= pg_wd;
      pg_q <= pg_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (nx_we) nx_mem[nx_wa] <= nx_wd;
      nx_q <= nx_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (pv_we) pv_mem[pv_wa] <= pv_wd;
      pv_q <= pv_mem[rd_addr_ff];
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule
`default_nettype wire
